// ===== sv/ipc_rendezvous_matcher_assert.svh =====
// Assertion helpers for the rendezvous matcher.
// Both expect clk and rst_n in scope.
`ifndef IPC_RENDEZVOUS_MATCHER_ASSERT_SVH
`define IPC_RENDEZVOUS_MATCHER_ASSERT_SVH

// cond must hold in the same cycle as trig
`define IRM_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("rendezvous matcher check failed");

// cond must hold in the cycle after trig
`define IRM_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("rendezvous matcher check failed");

`endif

// ===== sv/irm_pkg.sv =====
package irm_pkg;

  // fixed field widths of the request and result words
  localparam int CALLER_W  = 4;
  localparam int PARTNER_W = 5;
  localparam int BUF_W     = 16;
  localparam int STATE_W   = 2;

  // defaults for the top-level parameters
  localparam int DEF_NUM_PROCS = 16;
  localparam int DEF_ADDR_BITS = 16;

  // partner code for a receive from any sender
  localparam logic [PARTNER_W-1:0] ANY_PARTNER = 5'd16;

  // request codes
  localparam logic ACT_SEND = 1'b0;
  localparam logic ACT_RECV = 1'b1;

  // per-process wait state
  typedef enum logic [STATE_W-1:0] {
    WS_NEUTRAL = 2'd0,
    WS_SEND    = 2'd1,
    WS_RECV    = 2'd2
  } wstate_t;

  // sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXAMINE,
    S_EMIT
  } fsm_t;

  // one result word
  typedef struct packed {
    logic                caller_blocks;
    logic                copy_valid;
    logic [CALLER_W-1:0] copy_src_proc;
    logic [BUF_W-1:0]    copy_src_addr;
    logic [CALLER_W-1:0] copy_dst_proc;
    logic [BUF_W-1:0]    copy_dst_addr;
    logic                stamp_sender;
    logic [CALLER_W-1:0] released_proc;
  } result_t;

endpackage

// ===== sv/ipc_rendezvous_matcher.sv =====
// Rendezvous matcher for synchronous send/receive. Each process owns one
// entry (wait state, partner, buffer offset) in a single-port-read entry
// RAM. A request to a named partner reads that partner's entry once: the
// read starts as the word is accepted, S_EXAMINE decides the match, and
// S_EMIT loads the result into the output register and returns the
// sequencer to idle. A receive from any sender walks the table one entry
// per cycle from process 0, stopping at the first sender waiting on the
// caller or at the last entry. That walk through the one read port sets
// the rate.
// One request is in flight at a time; the next word is accepted as soon
// as the sequencer is idle, even while the previous result still waits in
// the output register. A new result waits in the sequencer while the
// output register stays full.
// Entry wait states come out of reset neutral through per-entry valid
// flops, so no clearing pass runs after reset.
module ipc_rendezvous_matcher
  import irm_pkg::*;
#(
  parameter int NUM_PROCS = DEF_NUM_PROCS,
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [CALLER_W-1:0]  in_caller,
  input  logic [PARTNER_W-1:0] in_partner,
  input  logic [BUF_W-1:0]     in_buffer_addr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_caller_blocks,
  output logic                 out_copy_valid,
  output logic [CALLER_W-1:0]  out_copy_src_proc,
  output logic [BUF_W-1:0]     out_copy_src_addr,
  output logic [CALLER_W-1:0]  out_copy_dst_proc,
  output logic [BUF_W-1:0]     out_copy_dst_addr,
  output logic                 out_stamp_sender,
  output logic [CALLER_W-1:0]  out_released_proc
);

  localparam int PID_W = $clog2(NUM_PROCS);
  localparam int ENT_W = STATE_W + PARTNER_W + ADDR_BITS;
  localparam logic [PID_W-1:0] LAST_PID = PID_W'(NUM_PROCS - 1);

  // sequencer and request registers
  fsm_t                 fsm_r, fsm_nxt;
  logic                 act_r, act_nxt;
  logic [CALLER_W-1:0]  caller_r, caller_nxt;
  logic [PARTNER_W-1:0] partner_r, partner_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic                 any_r, any_nxt;
  logic                 tgt_ok_r, tgt_ok_nxt;
  logic [PID_W-1:0]     idx_r, idx_nxt;
  result_t              res_r, res_nxt;
  result_t              out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // entry RAM and valid flops
  logic                 wr_en;
  logic [PID_W-1:0]     wr_addr;
  logic [ENT_W-1:0]     wr_data;
  logic [PID_W-1:0]     rd_addr;
  logic [ENT_W-1:0]     rd_data;
  logic [NUM_PROCS-1:0] vld_r;
  logic                 rd_vld_r;

  // decoded read entry
  logic [STATE_W-1:0]   rd_st;
  logic [PARTNER_W-1:0] rd_partner;
  logic [ADDR_BITS-1:0] rd_buf;
  logic                 hit;
  logic [PARTNER_W-1:0] me5;

  // request decode at the input
  logic in_fire;
  logic in_any;
  logic in_partner_ok;
  logic in_caller_ok;

  assign in_fire       = in_valid && in_ready;
  assign in_any        = (in_action == ACT_RECV) && (in_partner == ANY_PARTNER);
  assign in_partner_ok = (in_partner != ANY_PARTNER) && (int'(in_partner) < NUM_PROCS);
  assign in_caller_ok  = int'(in_caller) < NUM_PROCS;

  irm_entry_ram #(
    .DEPTH (NUM_PROCS),
    .WIDTH (ENT_W),
    .AW    (PID_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // entry fields; an entry never written reads neutral
  assign rd_st      = rd_vld_r ? rd_data[ENT_W-1 -: STATE_W] : WS_NEUTRAL;
  assign rd_partner = rd_data[ADDR_BITS +: PARTNER_W];
  assign rd_buf     = rd_data[ADDR_BITS-1:0];
  assign me5        = PARTNER_W'(caller_r);

  // match test against the entry at idx_r
  always_comb begin
    if (act_r == ACT_SEND) begin
      hit = tgt_ok_r && (rd_st == WS_RECV) &&
            ((rd_partner == me5) || (rd_partner == ANY_PARTNER));
    end else begin
      hit = tgt_ok_r && (rd_st == WS_SEND) && (rd_partner == me5);
    end
  end

  // sequencer: next state, RAM access, result
  always_comb begin
    fsm_nxt       = fsm_r;
    act_nxt       = act_r;
    caller_nxt    = caller_r;
    partner_nxt   = partner_r;
    addr_nxt      = addr_r;
    any_nxt       = any_r;
    tgt_ok_nxt    = tgt_ok_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rd_data;
    rd_addr       = idx_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (fsm_r)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = (in_partner_ok && !in_any) ? PID_W'(in_partner) : '0;
        if (in_fire) begin
          act_nxt     = in_action;
          caller_nxt  = in_caller;
          partner_nxt = in_partner;
          addr_nxt    = ADDR_BITS'(in_buffer_addr);
          any_nxt     = in_any;
          tgt_ok_nxt  = in_any || in_partner_ok;
          idx_nxt     = rd_addr;
          if (in_caller_ok) begin
            fsm_nxt = S_EXAMINE;
          end else begin
            // unknown caller: nothing recorded, all-zero result
            res_nxt = '0;
            fsm_nxt = S_EMIT;
          end
        end
      end

      S_EXAMINE: begin
        res_nxt = '0;
        if (hit) begin
          // release partner, issue the copy
          wr_en   = 1'b1;
          wr_addr = idx_r;
          wr_data = {WS_NEUTRAL, rd_partner, rd_buf};
          res_nxt.copy_valid    = 1'b1;
          res_nxt.released_proc = CALLER_W'(idx_r);
          if (act_r == ACT_SEND) begin
            res_nxt.copy_src_proc = caller_r;
            res_nxt.copy_src_addr = BUF_W'(addr_r);
            res_nxt.copy_dst_proc = CALLER_W'(idx_r);
            res_nxt.copy_dst_addr = BUF_W'(rd_buf);
            res_nxt.stamp_sender  = 1'b1;
          end else begin
            res_nxt.copy_src_proc = CALLER_W'(idx_r);
            res_nxt.copy_src_addr = BUF_W'(rd_buf);
            res_nxt.copy_dst_proc = caller_r;
            res_nxt.copy_dst_addr = BUF_W'(addr_r);
          end
          fsm_nxt = S_EMIT;
        end else if (any_r && (idx_r != LAST_PID)) begin
          // scan on to the next entry
          idx_nxt = idx_r + 1'b1;
          rd_addr = idx_r + 1'b1;
        end else begin
          // no partner ready: record the caller and block
          wr_en   = 1'b1;
          wr_addr = PID_W'(caller_r);
          wr_data = {(act_r == ACT_RECV) ? WS_RECV : WS_SEND, partner_r, addr_r};
          res_nxt.caller_blocks = 1'b1;
          fsm_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          fsm_nxt       = S_IDLE;
        end
      end

      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      fsm_r       <= fsm_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    caller_r  <= caller_nxt;
    partner_r <= partner_nxt;
    addr_r    <= addr_nxt;
    any_r     <= any_nxt;
    tgt_ok_r  <= tgt_ok_nxt;
    idx_r     <= idx_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    rd_vld_r  <= vld_r[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_caller_blocks = out_r.caller_blocks;
  assign out_copy_valid    = out_r.copy_valid;
  assign out_copy_src_proc = out_r.copy_src_proc;
  assign out_copy_src_addr = out_r.copy_src_addr;
  assign out_copy_dst_proc = out_r.copy_dst_proc;
  assign out_copy_dst_addr = out_r.copy_dst_addr;
  assign out_stamp_sender  = out_r.stamp_sender;
  assign out_released_proc = out_r.released_proc;

  // checks
`include "ipc_rendezvous_matcher_assert.svh"

  `IRM_ASSERT_NOW(a_copy_not_blocked, out_valid && out_copy_valid, !out_caller_blocks)
  `IRM_ASSERT_NOW(a_write_on_decide, wr_en, fsm_r == S_EXAMINE)
  `IRM_ASSERT_NOW(a_idx_in_range, fsm_r == S_EXAMINE, int'(idx_r) < NUM_PROCS)
  `IRM_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, fsm_r != S_IDLE)

endmodule

// ===== sv/irm_entry_ram.sv =====
// Process entry table: one write port, one read port, registered read data.
module irm_entry_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 23,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== dv/tb_ipc_rendezvous_matcher.sv =====
module tb_ipc_rendezvous_matcher;
  import irm_pkg::*;

  localparam int NUM_PROCS  = DEF_NUM_PROCS;
  localparam int ADDR_BITS  = DEF_ADDR_BITS;
  localparam int RAND_WORDS = 1225;
  localparam int IDLE_PCT   = 21;
  localparam int DRAIN      = 2 * NUM_PROCS + 8;
  localparam int LIMIT      = 200000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_action;
  logic [CALLER_W-1:0] in_caller;
  logic [PARTNER_W-1:0] in_partner;
  logic [BUF_W-1:0] in_buffer_addr;
  logic out_valid;
  logic out_ready;
  logic out_caller_blocks;
  logic out_copy_valid;
  logic [CALLER_W-1:0] out_copy_src_proc;
  logic [BUF_W-1:0] out_copy_src_addr;
  logic [CALLER_W-1:0] out_copy_dst_proc;
  logic [BUF_W-1:0] out_copy_dst_addr;
  logic out_stamp_sender;
  logic [CALLER_W-1:0] out_released_proc;

  // shadow copy of the per-process entries
  wstate_t              mate_state   [NUM_PROCS];
  logic [PARTNER_W-1:0] mate_partner [NUM_PROCS];
  logic [BUF_W-1:0]     mate_buf     [NUM_PROCS];

  result_t owed_replies[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;

  // directed word with an optional typed-in result
  typedef struct {
    logic                 act;
    logic [CALLER_W-1:0]  me;
    logic [PARTNER_W-1:0] pt;
    logic [BUF_W-1:0]     addr;
    logic                 fixed;
    result_t              res;
  } dir_row_t;

  dir_row_t dir_tab[$];

  ipc_rendezvous_matcher #(
    .NUM_PROCS(NUM_PROCS),
    .ADDR_BITS(ADDR_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_caller(in_caller),
    .in_partner(in_partner),
    .in_buffer_addr(in_buffer_addr),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_caller_blocks(out_caller_blocks),
    .out_copy_valid(out_copy_valid),
    .out_copy_src_proc(out_copy_src_proc),
    .out_copy_src_addr(out_copy_src_addr),
    .out_copy_dst_proc(out_copy_dst_proc),
    .out_copy_dst_addr(out_copy_dst_addr),
    .out_stamp_sender(out_stamp_sender),
    .out_released_proc(out_released_proc)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic result_t mk_res(logic blocks, logic valid, logic [3:0] sp,
                                     logic [15:0] sa, logic [3:0] dp, logic [15:0] da,
                                     logic stamp, logic [3:0] rel);
    result_t r;
    r = {blocks, valid, sp, sa, dp, da, stamp, rel};
    return r;
  endfunction

  // matches a request against the shadow entries and updates them
  function automatic result_t predict_rendezvous(logic act, logic [CALLER_W-1:0] me,
                                                 logic [PARTNER_W-1:0] pt,
                                                 logic [BUF_W-1:0] addr);
    result_t r;
    logic hit;
    int i;
    r = '0;
    hit = 1'b0;
    if (act == ACT_SEND) begin
      if (pt < NUM_PROCS && mate_state[pt[3:0]] == WS_RECV &&
          (mate_partner[pt[3:0]] == {1'b0, me} || mate_partner[pt[3:0]] == ANY_PARTNER)) begin
        mate_state[pt[3:0]] = WS_NEUTRAL;
        r = mk_res(1'b0, 1'b1, me, addr, pt[3:0], mate_buf[pt[3:0]], 1'b1, pt[3:0]);
        hit = 1'b1;
      end
    end else if (pt == ANY_PARTNER) begin
      // lowest-numbered sender waiting on this caller wins
      for (i = 0; i < NUM_PROCS && !hit; i++) begin
        if (mate_state[i] == WS_SEND && mate_partner[i] == {1'b0, me}) begin
          mate_state[i] = WS_NEUTRAL;
          r = mk_res(1'b0, 1'b1, 4'(i), mate_buf[i], me, addr, 1'b0, 4'(i));
          hit = 1'b1;
        end
      end
    end else if (pt < NUM_PROCS && mate_state[pt[3:0]] == WS_SEND &&
                 mate_partner[pt[3:0]] == {1'b0, me}) begin
      mate_state[pt[3:0]] = WS_NEUTRAL;
      r = mk_res(1'b0, 1'b1, pt[3:0], mate_buf[pt[3:0]], me, addr, 1'b0, pt[3:0]);
      hit = 1'b1;
    end
    // no match: caller records its request and blocks
    if (!hit) begin
      mate_state[me]   = (act == ACT_SEND) ? WS_SEND : WS_RECV;
      mate_partner[me] = pt;
      mate_buf[me]     = addr;
      r.caller_blocks  = 1'b1;
    end
    return r;
  endfunction

  task automatic add_row(logic act, logic [CALLER_W-1:0] me, logic [PARTNER_W-1:0] pt,
                         logic [BUF_W-1:0] addr, logic fixed, result_t res);
    dir_row_t row;
    row.act = act;
    row.me = me;
    row.pt = pt;
    row.addr = addr;
    row.fixed = fixed;
    row.res = res;
    dir_tab.push_back(row);
  endtask

  // drive one request word, wait for acceptance, queue its result
  task automatic issue_word(logic act, logic [CALLER_W-1:0] me, logic [PARTNER_W-1:0] pt,
                            logic [BUF_W-1:0] addr, logic fixed, result_t res);
    result_t guess;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_caller      <= me;
    in_partner     <= pt;
    in_buffer_addr <= addr;
    do @(posedge clk); while (!in_ready);
    guess = predict_rendezvous(act, me, pt, addr);
    owed_replies.push_back(fixed ? res : guess);
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // result side: random stalls and field-by-field compare
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = owed_replies.pop_front();
          check_field("caller_blocks", 16'(out_caller_blocks), 16'(want.caller_blocks));
          check_field("copy_valid", 16'(out_copy_valid), 16'(want.copy_valid));
          check_field("copy_src_proc", 16'(out_copy_src_proc), 16'(want.copy_src_proc));
          check_field("copy_src_addr", out_copy_src_addr, want.copy_src_addr);
          check_field("copy_dst_proc", 16'(out_copy_dst_proc), 16'(want.copy_dst_proc));
          check_field("copy_dst_addr", out_copy_dst_addr, want.copy_dst_addr);
          check_field("stamp_sender", 16'(out_stamp_sender), 16'(want.stamp_sender));
          check_field("released_proc", 16'(out_released_proc), 16'(want.released_proc));
        end
      end
    end
  end

  initial begin
    result_t blocked;
    logic r_act;
    logic [CALLER_W-1:0] r_me;
    logic [PARTNER_W-1:0] r_pt;
    logic [BUF_W-1:0] r_addr;
    int n;
    int j;
    int pick;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_SEND;
    in_caller = '0;
    in_partner = '0;
    in_buffer_addr = '0;
    for (j = 0; j < NUM_PROCS; j++) begin
      mate_state[j] = WS_NEUTRAL;
      mate_partner[j] = '0;
      mate_buf[j] = '0;
    end
    blocked = mk_res(1'b1, 1'b0, 4'd0, 16'd0, 4'd0, 16'd0, 1'b0, 4'd0);

    // directed table
    add_row(ACT_SEND, 4'd0, 5'd1, 16'hFFFF, 1'b1, blocked);
    add_row(ACT_RECV, 4'd1, 5'd0, 16'h0000, 1'b1,
            mk_res(1'b0, 1'b1, 4'd0, 16'hFFFF, 4'd1, 16'h0000, 1'b0, 4'd1 - 4'd1));
    add_row(ACT_RECV, 4'd2, ANY_PARTNER, 16'h1234, 1'b1, blocked);
    add_row(ACT_SEND, 4'd15, 5'd2, 16'hABCD, 1'b1,
            mk_res(1'b0, 1'b1, 4'd15, 16'hABCD, 4'd2, 16'h1234, 1'b1, 4'd2));
    // unreachable partner, and a send to any
    add_row(ACT_SEND, 4'd3, 5'd31, 16'h5555, 1'b1, blocked);
    add_row(ACT_SEND, 4'd4, ANY_PARTNER, 16'hAAAA, 1'b1, blocked);
    add_row(ACT_RECV, 4'd5, ANY_PARTNER, 16'h0F0F, 1'b1, blocked);
    add_row(ACT_SEND, 4'd6, 5'd5, 16'h0001, 1'b1,
            mk_res(1'b0, 1'b1, 4'd6, 16'h0001, 4'd5, 16'h0F0F, 1'b1, 4'd5));
    add_row(ACT_RECV, 4'd7, 5'd17, 16'h8000, 1'b1, blocked);
    add_row(ACT_SEND, 4'd7, 5'd3, 16'h7777, 1'b0, '0);
    // request to self
    add_row(ACT_SEND, 4'd8, 5'd8, 16'h0808, 1'b0, '0);
    add_row(ACT_RECV, 4'd8, 5'd8, 16'h8080, 1'b0, '0);
    // receive from any picks the lowest waiting sender
    add_row(ACT_SEND, 4'd12, 5'd10, 16'hC00C, 1'b0, '0);
    add_row(ACT_SEND, 4'd9, 5'd10, 16'h9009, 1'b0, '0);
    add_row(ACT_SEND, 4'd11, 5'd10, 16'hB00B, 1'b0, '0);
    add_row(ACT_RECV, 4'd10, ANY_PARTNER, 16'h0A01, 1'b0, '0);
    add_row(ACT_RECV, 4'd10, ANY_PARTNER, 16'h0A02, 1'b0, '0);
    add_row(ACT_RECV, 4'd10, ANY_PARTNER, 16'h0A03, 1'b0, '0);
    // a blocking caller overwrites its entry
    add_row(ACT_SEND, 4'd13, 5'd14, 16'h1111, 1'b0, '0);
    add_row(ACT_SEND, 4'd13, 5'd14, 16'h2222, 1'b0, '0);
    add_row(ACT_RECV, 4'd14, 5'd13, 16'h3333, 1'b0, '0);
    // a matching caller keeps its own wait entry
    add_row(ACT_RECV, 4'd14, 5'd0, 16'h4444, 1'b0, '0);
    add_row(ACT_RECV, 4'd15, 5'd14, 16'h5A5A, 1'b0, '0);
    add_row(ACT_SEND, 4'd14, 5'd15, 16'hA5A5, 1'b0, '0);
    add_row(ACT_SEND, 4'd0, 5'd14, 16'h6666, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k])
      issue_word(dir_tab[k].act, dir_tab[k].me, dir_tab[k].pt, dir_tab[k].addr,
                 dir_tab[k].fixed, dir_tab[k].res);

    // random words, part of them aimed at completing a waiting entry
    for (n = 0; n < RAND_WORDS; n++) begin
      calm = (n >= 450 && n < 750);
      r_act  = 1'($urandom_range(0, 1));
      r_me   = 4'($urandom_range(0, NUM_PROCS - 1));
      r_pt   = 5'($urandom_range(0, NUM_PROCS - 1));
      r_addr = 16'($urandom());
      pick   = $urandom_range(0, 99);
      if (pick < 55) begin
        j = $urandom_range(0, NUM_PROCS - 1);
        if (mate_state[j] == WS_SEND && mate_partner[j] < NUM_PROCS) begin
          r_act = ACT_RECV;
          r_me  = mate_partner[j][3:0];
          r_pt  = ($urandom_range(0, 1) != 0) ? ANY_PARTNER : 5'(j);
        end else if (mate_state[j] == WS_RECV && mate_partner[j] <= ANY_PARTNER) begin
          r_act = ACT_SEND;
          if (mate_partner[j] != ANY_PARTNER)
            r_me = mate_partner[j][3:0];
          r_pt = 5'(j);
        end
      end else if (pick < 65) begin
        // partners that nothing can match, or any
        r_pt = 5'($urandom_range(16, 31));
      end else if (pick < 80) begin
        r_act = ACT_RECV;
        r_pt  = ANY_PARTNER;
      end
      issue_word(r_act, r_me, r_pt, r_addr, 1'b0, '0);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/irm_pkg.sv
sv/irm_entry_ram.sv
sv/ipc_rendezvous_matcher.sv
dv/tb_ipc_rendezvous_matcher.sv
